/* rtl/bre_pkg.sv */
`default_nettype none

package bre_pkg;

  // Default image bounds
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;
  localparam logic [CFG_W-1:0]     ROW_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0]     COL_COUNT_RST = 7'd64;

  // Result kinds
  localparam int WHICH_W = 2;
  localparam logic [WHICH_W-1:0] WHICH_AREA   = 2'd0;
  localparam logic [WHICH_W-1:0] WHICH_HEIGHT = 2'd1;
  localparam logic [WHICH_W-1:0] WHICH_WIDTH  = 2'd2;

  // Result field widths
  localparam int OUT_ROW_W    = 6;
  localparam int OUT_COL_W    = 6;
  localparam int OUT_HEIGHT_W = 7;
  localparam int OUT_WIDTH_W  = 7;
  localparam int OUT_AREA_W   = 13;

  // Stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 40;

endpackage

`default_nettype wire

/* rtl/bre_ram.sv */
`default_nettype none

module bre_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/bre_best.sv */
`default_nettype none

module bre_best #(
  parameter int MAX_ROWS = bre_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bre_pkg::MAX_COLS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 clear,
  input  wire logic                                 cand_valid,
  input  wire logic [$clog2(MAX_ROWS)-1:0]          cand_row,
  input  wire logic [$clog2(MAX_COLS)-1:0]          cand_col,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]        cand_h,
  input  wire logic [$clog2(MAX_COLS+1)-1:0]        cand_w,
  input  wire logic [$clog2(MAX_ROWS+1)+$clog2(MAX_COLS+1)-1:0] cand_a,
  input  wire logic [bre_pkg::WHICH_W-1:0]          sel,
  output logic                                      rec_found,
  output logic      [$clog2(MAX_ROWS)-1:0]          rec_row,
  output logic      [$clog2(MAX_COLS)-1:0]          rec_col,
  output logic      [$clog2(MAX_ROWS+1)-1:0]        rec_h,
  output logic      [$clog2(MAX_COLS+1)-1:0]        rec_w,
  output logic      [$clog2(MAX_ROWS+1)+$clog2(MAX_COLS+1)-1:0] rec_a
);

  import bre_pkg::*;

  localparam int RI_W   = $clog2(MAX_ROWS);
  localparam int CI_W   = $clog2(MAX_COLS);
  localparam int HW     = $clog2(MAX_ROWS + 1);
  localparam int WW     = $clog2(MAX_COLS + 1);
  localparam int AREA_W = HW + WW;

  typedef struct packed {
    logic [RI_W-1:0]   row;
    logic [CI_W-1:0]   col;
    logic [HW-1:0]     h;
    logic [WW-1:0]     w;
    logic [AREA_W-1:0] a;
  } rect_t;

  rect_t cand;
  rect_t best_area;
  rect_t best_height;
  rect_t best_width;
  rect_t rec;

  assign cand = '{row: cand_row, col: cand_col, h: cand_h, w: cand_w, a: cand_a};

  // Candidates arrive in reverse scan order: take ties so the earliest corner wins
  always_ff @(posedge clk) begin
    if (clear) begin
      best_area   <= '0;
      best_height <= '0;
      best_width  <= '0;
    end else if (cand_valid) begin
      if (cand.a >= best_area.a) begin
        best_area <= cand;
      end
      if (cand.h >= best_height.h) begin
        best_height <= cand;
      end
      if (cand.w >= best_width.w) begin
        best_width <= cand;
      end
    end
  end

  always_comb begin
    case (sel)
      WHICH_AREA:   rec = best_area;
      WHICH_HEIGHT: rec = best_height;
      WHICH_WIDTH:  rec = best_width;
      default:      rec = '0;
    endcase
  end

  assign rec_found = (rec.a != '0);
  assign rec_row   = rec.row;
  assign rec_col   = rec.col;
  assign rec_h     = rec.h;
  assign rec_w     = rec.w;
  assign rec_a     = rec.a;

endmodule

`default_nettype wire

/* rtl/binary_rectangle_extremes_core.sv */
`default_nettype none

// Binary image rectangle extremes.
// Feed one pixel per transfer on the s_ channel (s_tdata[0], row-major).
// Pixels load at one per cycle into the image RAM. The transfer that brings
// the pixel count to row_count*col_count closes the frame and starts the
// search; s_tready stays low until the report has been handed to the output
// register. The search walks the image backward through a pixel read, an
// upper-neighbor read and an update for each pixel, bounded by the single
// read port of the image RAM. Three results follow in order: greatest area,
// greatest height, greatest width (kind in m_tuser, m_tlast on the third).
// A stalled m_tready holds the current result in the output register and
// holds the search at the next one. Configuration writes (cfg_index 0 =
// row_count, 1 = col_count) are taken only in the load state and belong
// between frames or between pixels. Reset returns to the load state with an
// empty frame and 64 x 64 dimensions; the image RAM itself is not cleared.
module binary_rectangle_extremes_core #(
  parameter int MAX_ROWS = bre_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bre_pkg::MAX_COLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bre_pkg::CFG_W-1:0]      cfg_data,
  // Pixel stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [bre_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] pixel, [7:1] zero
  // Result stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [bre_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] found, [6:1] top_row,
                                                         // [12:7] left_col, [19:13] height,
                                                         // [26:20] width, [39:27] area
  output logic      [bre_pkg::WHICH_W-1:0]    m_tuser,   // [1:0] which
  output logic                                m_tlast
);

  import bre_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int LCW    = $clog2(DEPTH + 1);
  localparam int RI_W   = $clog2(MAX_ROWS);
  localparam int CI_W   = $clog2(MAX_COLS);
  localparam int HW     = $clog2(MAX_ROWS + 1);
  localparam int WW     = $clog2(MAX_COLS + 1);
  localparam int TOT_W  = HW + WW;
  localparam int AREA_W = HW + WW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_PX,
    ST_RD_UP,
    ST_PROC,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  state_t state;

  // Configuration and clamped dimensions
  logic [CFG_W-1:0] row_cfg;
  logic [CFG_W-1:0] col_cfg;
  logic [HW-1:0]    rows;
  logic [WW-1:0]    cols;
  logic [TOT_W-1:0] total;

  // Load side
  logic [LCW-1:0] load_count;
  logic           room;
  logic [LCW-1:0] cnt_inc;
  logic           frame_done;
  logic           in_xfer;

  // Scan position, walked from the last pixel back to the first
  logic [RI_W-1:0] scan_r;
  logic [CI_W-1:0] scan_c;
  logic [AW-1:0]   scan_addr;
  logic [AW-1:0]   up_addr;
  logic            pix_q;
  logic [WW-1:0]   right_q;

  // RAM ports
  logic            img_wr_en;
  logic [AW-1:0]   img_rd_addr;
  logic            img_rd;
  logic            run_wr_en;
  logic [HW-1:0]   run_rd;

  // Update step
  logic            up_set;
  logic            last_row;
  logic            last_col;
  logic [HW-1:0]   down;
  logic [WW-1:0]   right;

  // Pending corner, judged once its left neighbor is known
  logic              pend_valid;
  logic [RI_W-1:0]   pend_r;
  logic [CI_W-1:0]   pend_c;
  logic [HW-1:0]     pend_h;
  logic [WW-1:0]     pend_w;
  logic [AREA_W-1:0] pend_a;
  logic              ev_valid;

  // Report
  logic [WHICH_W-1:0] emit_sel;
  logic               rec_found;
  logic [RI_W-1:0]    rec_row;
  logic [CI_W-1:0]    rec_col;
  logic [HW-1:0]      rec_h;
  logic [WW-1:0]      rec_w;
  logic [AREA_W-1:0]  rec_a;

  // Zero reads as one, anything above the bound reads as the bound
  always_comb begin
    if (row_cfg == '0) begin
      rows = HW'(1);
    end else if (32'(row_cfg) > 32'(MAX_ROWS)) begin
      rows = HW'(MAX_ROWS);
    end else begin
      rows = HW'(row_cfg);
    end
    if (col_cfg == '0) begin
      cols = WW'(1);
    end else if (32'(col_cfg) > 32'(MAX_COLS)) begin
      cols = WW'(MAX_COLS);
    end else begin
      cols = WW'(col_cfg);
    end
  end

  assign total = TOT_W'(rows) * TOT_W'(cols);

  // Hold the dimensions steady while a search or report is under way
  assign cfg_ready  = (state == ST_LOAD);
  assign s_tready   = (state == ST_LOAD);
  assign in_xfer    = s_tvalid && s_tready;
  assign room       = (load_count < LCW'(DEPTH));
  assign cnt_inc    = load_count + LCW'(room);
  // A shrink mid-frame closes the frame on the next pixel
  assign frame_done = (TOT_W'(cnt_inc) >= total);

  assign img_wr_en   = in_xfer && room;
  assign up_addr     = scan_addr - AW'(cols);
  assign img_rd_addr = (state == ST_RD_UP) ? up_addr : scan_addr;
  assign run_wr_en   = (state == ST_PROC);

  bre_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_img_ram (
    .clk     (clk),
    .wr_en   (img_wr_en),
    .wr_addr (AW'(load_count)),
    .wr_data (s_tdata[0]),
    .rd_addr (img_rd_addr),
    .rd_data (img_rd)
  );

  // Downward run length per column, one row below the scan position
  bre_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_COLS)
  ) u_run_ram (
    .clk     (clk),
    .wr_en   (run_wr_en),
    .wr_addr (scan_c),
    .wr_data (down),
    .rd_addr (scan_c),
    .rd_data (run_rd)
  );

  // Runs grow backward: the bottom row and rightmost column start at one
  always_comb begin
    up_set   = (scan_r != '0) && img_rd;
    last_row = (HW'(scan_r) == rows - HW'(1));
    last_col = (WW'(scan_c) == cols - WW'(1));
    if (!pix_q) begin
      down = '0;
    end else if (last_row) begin
      down = HW'(1);
    end else begin
      down = run_rd + HW'(1);
    end
    if (!pix_q) begin
      right = '0;
    end else if (last_col) begin
      right = WW'(1);
    end else begin
      right = right_q + WW'(1);
    end
  end

  // The pixel now under update is the left neighbor of the pending one,
  // unless the pending one sits in column zero
  assign ev_valid = pend_valid &&
                    (((state == ST_PROC) && ((pend_c == '0) || !pix_q)) ||
                     (state == ST_FLUSH));

  bre_best #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_best (
    .clk        (clk),
    .clear      (in_xfer && frame_done),
    .cand_valid (ev_valid),
    .cand_row   (pend_r),
    .cand_col   (pend_c),
    .cand_h     (pend_h),
    .cand_w     (pend_w),
    .cand_a     (pend_a),
    .sel        (emit_sel),
    .rec_found  (rec_found),
    .rec_row    (rec_row),
    .rec_col    (rec_col),
    .rec_h      (rec_h),
    .rec_w      (rec_w),
    .rec_a      (rec_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      row_cfg    <= ROW_COUNT_RST;
      col_cfg    <= COL_COUNT_RST;
      load_count <= '0;
      pend_valid <= 1'b0;
      emit_sel   <= WHICH_AREA;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_COUNT: row_cfg <= cfg_data;
          CFG_COL_COUNT: col_cfg <= cfg_data;
          default:       ;
        endcase
      end

      // Drop the result once the receiver has taken it, unless the next one
      // moves in at the same edge
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (frame_done) begin
              load_count <= '0;
              scan_r     <= RI_W'(rows - HW'(1));
              scan_c     <= CI_W'(cols - WW'(1));
              scan_addr  <= AW'(total - TOT_W'(1));
              pend_valid <= 1'b0;
              state      <= ST_RD_PX;
            end else begin
              load_count <= cnt_inc;
            end
          end
        end
        ST_RD_PX: begin
          state <= ST_RD_UP;
        end
        ST_RD_UP: begin
          pix_q <= img_rd;
          state <= ST_PROC;
        end
        ST_PROC: begin
          right_q    <= right;
          pend_valid <= pix_q && !up_set;
          pend_r     <= scan_r;
          pend_c     <= scan_c;
          pend_h     <= down;
          pend_w     <= right;
          pend_a     <= AREA_W'(down) * AREA_W'(right);
          if (scan_addr == '0) begin
            state <= ST_FLUSH;
          end else begin
            scan_addr <= scan_addr - AW'(1);
            if (scan_c == '0) begin
              scan_c <= CI_W'(cols - WW'(1));
              scan_r <= scan_r - RI_W'(1);
            end else begin
              scan_c <= scan_c - CI_W'(1);
            end
            state <= ST_RD_PX;
          end
        end
        ST_FLUSH: begin
          pend_valid <= 1'b0;
          emit_sel   <= WHICH_AREA;
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= emit_sel;
            m_tlast  <= (emit_sel == WHICH_WIDTH);
            m_tdata  <= {OUT_AREA_W'(rec_a), OUT_WIDTH_W'(rec_w), OUT_HEIGHT_W'(rec_h),
                         OUT_COL_W'(rec_col), OUT_ROW_W'(rec_row), rec_found};
            if (emit_sel == WHICH_WIDTH) begin
              state <= ST_LOAD;
            end else begin
              emit_sel <= emit_sel + WHICH_W'(1);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Closing a frame empties the load counter and starts the backward walk
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && frame_done) |=> (state == ST_RD_PX && load_count == '0))
    else $error("frame close did not start the search");

  // Only a set pixel can become a corner, so a judged candidate has real runs
  assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (pend_h != '0 && pend_w != '0 && pend_a != '0))
    else $error("empty candidate judged as a corner");

  // The width report closes every report and nothing else does
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == WHICH_WIDTH)))
    else $error("tlast does not match the result kind");

endmodule

`default_nettype wire
